// ===== rtl/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_ERD,
    ST_ECAP,
    ST_EOUT
  } state_t;

  typedef logic [7:0][31:0] work_t;

  localparam logic [0:0] CMD_ABSORB = 1'b0;
  localparam logic [0:0] CMD_FINISH = 1'b1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] EXTRA_FILL = 6'd56;

  function automatic logic [31:0] ror(input logic [31:0] x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] i);
    case (i)
      3'd0: init_hash = 32'h6A09E667;
      3'd1: init_hash = 32'hBB67AE85;
      3'd2: init_hash = 32'h3C6EF372;
      3'd3: init_hash = 32'hA54FF53A;
      3'd4: init_hash = 32'h510E527F;
      3'd5: init_hash = 32'h9B05688C;
      3'd6: init_hash = 32'h1F83D9AB;
      default: init_hash = 32'h5BE0CD19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] t);
    case (t)
      6'd0: round_k = 32'h428A2F98;  6'd1: round_k = 32'h71374491;
      6'd2: round_k = 32'hB5C0FBCF;  6'd3: round_k = 32'hE9B5DBA5;
      6'd4: round_k = 32'h3956C25B;  6'd5: round_k = 32'h59F111F1;
      6'd6: round_k = 32'h923F82A4;  6'd7: round_k = 32'hAB1C5ED5;
      6'd8: round_k = 32'hD807AA98;  6'd9: round_k = 32'h12835B01;
      6'd10: round_k = 32'h243185BE; 6'd11: round_k = 32'h550C7DC3;
      6'd12: round_k = 32'h72BE5D74; 6'd13: round_k = 32'h80DEB1FE;
      6'd14: round_k = 32'h9BDC06A7; 6'd15: round_k = 32'hC19BF174;
      6'd16: round_k = 32'hE49B69C1; 6'd17: round_k = 32'hEFBE4786;
      6'd18: round_k = 32'h0FC19DC6; 6'd19: round_k = 32'h240CA1CC;
      6'd20: round_k = 32'h2DE92C6F; 6'd21: round_k = 32'h4A7484AA;
      6'd22: round_k = 32'h5CB0A9DC; 6'd23: round_k = 32'h76F988DA;
      6'd24: round_k = 32'h983E5152; 6'd25: round_k = 32'hA831C66D;
      6'd26: round_k = 32'hB00327C8; 6'd27: round_k = 32'hBF597FC7;
      6'd28: round_k = 32'hC6E00BF3; 6'd29: round_k = 32'hD5A79147;
      6'd30: round_k = 32'h06CA6351; 6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27B70A85; 6'd33: round_k = 32'h2E1B2138;
      6'd34: round_k = 32'h4D2C6DFC; 6'd35: round_k = 32'h53380D13;
      6'd36: round_k = 32'h650A7354; 6'd37: round_k = 32'h766A0ABB;
      6'd38: round_k = 32'h81C2C92E; 6'd39: round_k = 32'h92722C85;
      6'd40: round_k = 32'hA2BFE8A1; 6'd41: round_k = 32'hA81A664B;
      6'd42: round_k = 32'hC24B8B70; 6'd43: round_k = 32'hC76C51A3;
      6'd44: round_k = 32'hD192E819; 6'd45: round_k = 32'hD6990624;
      6'd46: round_k = 32'hF40E3585; 6'd47: round_k = 32'h106AA070;
      6'd48: round_k = 32'h19A4C116; 6'd49: round_k = 32'h1E376C08;
      6'd50: round_k = 32'h2748774C; 6'd51: round_k = 32'h34B0BCB5;
      6'd52: round_k = 32'h391C0CB3; 6'd53: round_k = 32'h4ED8AA4A;
      6'd54: round_k = 32'h5B9CCA4F; 6'd55: round_k = 32'h682E6FF3;
      6'd56: round_k = 32'h748F82EE; 6'd57: round_k = 32'h78A5636F;
      6'd58: round_k = 32'h84C87814; 6'd59: round_k = 32'h8CC70208;
      6'd60: round_k = 32'h90BEFFFA; 6'd61: round_k = 32'hA4506CEB;
      6'd62: round_k = 32'hBEF9A3F7; default: round_k = 32'hC67178F2;
    endcase
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
  endfunction

  // One compression round; element 0 is a, element 7 is h.
  function automatic work_t do_round(input work_t v, input logic [31:0] w,
                                     input logic [31:0] k);
    logic [31:0] s1;
    logic [31:0] ch;
    logic [31:0] s0;
    logic [31:0] mj;
    logic [31:0] t1;
    logic [31:0] t2;
    work_t r;
    s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
    ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1 = v[7] + s1 + ch + k + w;
    s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
    mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2 = s0 + mj;
    r[7] = v[6];
    r[6] = v[5];
    r[5] = v[4];
    r[4] = v[3] + t1;
    r[3] = v[2];
    r[2] = v[1];
    r[1] = v[0];
    r[0] = t1 + t2;
    do_round = r;
  endfunction

endpackage

// ===== rtl/sha256_byte_stream_hasher_core.sv =====
// Top level of the SHA-256 byte stream hasher: sequencer, round datapath, memories.
//
//  channel | ports                                        | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid in_ready in_cmd in_data_byte        | input
//  out     | out_valid out_ready out_word_index           | output
//          | out_digest_word out_last                     |
//
// An absorb transaction is taken in IDLE; every 64th byte adds a compression whose
// expanded rounds are paced by the single read port of the
// schedule memory (four reads per expanded round). A finish transaction pads
// the block, compresses one or two blocks, then returns eight output
// transactions, each held until out_ready. in_ready is low while busy.
// Reset is synchronous; the chaining memory reads as the initial hash at once.
module sha256_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_word_index,
  output logic [31:0] out_digest_word,
  output logic        out_last
);

  sha256_pkg::state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [5:0]  t_r, t_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic        fin_r, fin_nxt;
  logic        extra_r, extra_nxt;
  logic        first_r, first_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [31:0] wacc_r, wacc_nxt;
  sha256_pkg::work_t v_r, v_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_word_r, out_word_nxt;
  logic [2:0]  e_r, e_nxt;

  logic        w_we;
  logic [3:0]  w_wa;
  logic [31:0] w_wd;
  logic [3:0]  w_ra;
  logic [31:0] w_q;
  logic        h_clr;
  logic        h_we;
  logic [2:0]  h_wa;
  logic [31:0] h_wd;
  logic [2:0]  h_ra;
  logic [31:0] h_q;

  logic [2:0]  cm1;
  logic [31:0] pad_word;
  logic [31:0] w_cur;
  logic [31:0] len_hi;
  logic [31:0] len_lo;

  assign cm1    = 3'(cnt_r - 4'd1);
  assign len_hi = total_r[60:29];
  assign len_lo = {total_r[28:0], 3'b000};

  // Form the word that carries the pad marker after any pending bytes
  always_comb begin
    case (fill_r[1:0])
      2'd0: pad_word = {sha256_pkg::PAD_BYTE, 24'h0};
      2'd1: pad_word = {acc_r[7:0], sha256_pkg::PAD_BYTE, 16'h0};
      2'd2: pad_word = {acc_r[15:0], sha256_pkg::PAD_BYTE, 8'h0};
      default: pad_word = {acc_r[23:0], sha256_pkg::PAD_BYTE};
    endcase
  end

  sha256_sched_ram u_sched (
    .clk (clk),
    .we  (w_we),
    .wa  (w_wa),
    .wd  (w_wd),
    .ra  (w_ra),
    .q   (w_q)
  );

  sha256_chain_ram u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .clr   (h_clr),
    .we    (h_we),
    .wa    (h_wa),
    .wd    (h_wd),
    .ra    (h_ra),
    .q     (h_q)
  );

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sha256_pkg::ST_IDLE;
      fill_r      <= '0;
      total_r     <= '0;
      fin_r       <= 1'b0;
      extra_r     <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      t_r         <= '0;
      ph_r        <= '0;
      idx_r       <= '0;
      e_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      fin_r       <= fin_nxt;
      extra_r     <= extra_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      t_r         <= t_nxt;
      ph_r        <= ph_nxt;
      idx_r       <= idx_nxt;
      e_r         <= e_nxt;
    end
  end

  // Hold payload state
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    wacc_r     <= wacc_nxt;
    v_r        <= v_nxt;
    out_word_r <= out_word_nxt;
  end

  // Sequence absorb, padding, compression and digest output
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    ph_nxt        = ph_r;
    acc_nxt       = acc_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    fin_nxt       = fin_r;
    extra_nxt     = extra_r;
    first_nxt     = first_r;
    idx_nxt       = idx_r;
    wacc_nxt      = wacc_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    e_nxt         = e_r;
    in_ready      = 1'b0;
    w_we          = 1'b0;
    w_wa          = '0;
    w_wd          = '0;
    w_ra          = '0;
    w_cur         = w_q;
    h_clr         = 1'b0;
    h_we          = 1'b0;
    h_wa          = '0;
    h_wd          = '0;
    h_ra          = '0;
    case (state_r)
      sha256_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == sha256_pkg::CMD_ABSORB) begin
            acc_nxt   = {acc_r[23:0], in_data_byte};
            fill_nxt  = fill_r + 6'd1;
            total_nxt = total_r + 61'd1;
            if (fill_r[1:0] == 2'd3) begin
              w_we = 1'b1;
              w_wa = fill_r[5:2];
              w_wd = {acc_r[23:0], in_data_byte};
            end
            if (fill_r == 6'd63) begin
              fin_nxt   = 1'b0;
              cnt_nxt   = '0;
              state_nxt = sha256_pkg::ST_LOAD;
            end
          end else begin
            fin_nxt   = 1'b1;
            extra_nxt = (fill_r >= sha256_pkg::EXTRA_FILL);
            first_nxt = 1'b1;
            idx_nxt   = fill_r[5:2];
            state_nxt = sha256_pkg::ST_PAD;
          end
        end
      end
      sha256_pkg::ST_PAD: begin
        w_we = 1'b1;
        w_wa = idx_r;
        if (first_r) begin
          w_wd = pad_word;
        end else if (!extra_r && idx_r == 4'd14) begin
          w_wd = len_hi;
        end else if (!extra_r && idx_r == 4'd15) begin
          w_wd = len_lo;
        end
        first_nxt = 1'b0;
        if (idx_r == 4'd15) begin
          cnt_nxt   = '0;
          state_nxt = sha256_pkg::ST_LOAD;
        end else begin
          idx_nxt = idx_r + 4'd1;
        end
      end
      sha256_pkg::ST_LOAD: begin
        h_ra = cnt_r[2:0];
        if (cnt_r != 4'd0) begin
          v_nxt[cm1] = h_q;
        end
        if (cnt_r == 4'd8) begin
          t_nxt     = '0;
          ph_nxt    = '0;
          state_nxt = sha256_pkg::ST_ROUND;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      sha256_pkg::ST_ROUND: begin
        if (ph_r == 3'd0) begin
          w_ra   = t_r[3:0];
          ph_nxt = 3'd1;
        end else if (t_r[5:4] != 2'd0 && ph_r == 3'd1) begin
          wacc_nxt = w_q;
          w_ra     = t_r[3:0] + 4'd1;
          ph_nxt   = 3'd2;
        end else if (t_r[5:4] != 2'd0 && ph_r == 3'd2) begin
          wacc_nxt = wacc_r + sha256_pkg::small_sigma0(w_q);
          w_ra     = t_r[3:0] + 4'd9;
          ph_nxt   = 3'd3;
        end else if (t_r[5:4] != 2'd0 && ph_r == 3'd3) begin
          wacc_nxt = wacc_r + w_q;
          w_ra     = t_r[3:0] + 4'd14;
          ph_nxt   = 3'd4;
        end else begin
          // Finish the schedule word if expanded, then run the round
          if (t_r[5:4] != 2'd0) begin
            w_cur = wacc_r + sha256_pkg::small_sigma1(w_q);
            w_we  = 1'b1;
            w_wa  = t_r[3:0];
            w_wd  = w_cur;
          end
          v_nxt  = sha256_pkg::do_round(v_r, w_cur, sha256_pkg::round_k(t_r));
          ph_nxt = '0;
          if (t_r == 6'd63) begin
            cnt_nxt   = '0;
            state_nxt = sha256_pkg::ST_FOLD;
          end else begin
            t_nxt = t_r + 6'd1;
          end
        end
      end
      sha256_pkg::ST_FOLD: begin
        h_ra = cnt_r[2:0];
        if (cnt_r != 4'd0) begin
          h_we = 1'b1;
          h_wa = cm1;
          h_wd = h_q + v_r[cm1];
        end
        if (cnt_r == 4'd8) begin
          if (!fin_r) begin
            state_nxt = sha256_pkg::ST_IDLE;
          end else if (extra_r) begin
            extra_nxt = 1'b0;
            first_nxt = 1'b0;
            idx_nxt   = '0;
            state_nxt = sha256_pkg::ST_PAD;
          end else begin
            e_nxt     = '0;
            state_nxt = sha256_pkg::ST_ERD;
          end
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      sha256_pkg::ST_ERD: begin
        h_ra      = e_r;
        state_nxt = sha256_pkg::ST_ECAP;
      end
      sha256_pkg::ST_ECAP: begin
        out_word_nxt  = h_q;
        out_valid_nxt = 1'b1;
        state_nxt     = sha256_pkg::ST_EOUT;
      end
      sha256_pkg::ST_EOUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          if (e_r == 3'd7) begin
            // Drop the finished message and start over from the initial hash
            h_clr     = 1'b1;
            fill_nxt  = '0;
            total_nxt = '0;
            fin_nxt   = 1'b0;
            state_nxt = sha256_pkg::ST_IDLE;
          end else begin
            e_nxt     = e_r + 3'd1;
            state_nxt = sha256_pkg::ST_ERD;
          end
        end
      end
      default: begin
        state_nxt = sha256_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_word_index  = e_r;
  assign out_digest_word = out_word_r;
  assign out_last        = (e_r == 3'd7);

endmodule

// ===== rtl/sha256_sched_ram.sv =====
// Sixteen-word block and message schedule memory, one write and one read port.
module sha256_sched_ram (
  input  logic        clk,
  input  logic        we,
  input  logic [3:0]  wa,
  input  logic [31:0] wd,
  input  logic [3:0]  ra,
  output logic [31:0] q
);

  logic [31:0] mem [16];
  logic [31:0] q_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q_r <= mem[ra];
  end

  assign q = q_r;

endmodule

// ===== rtl/sha256_chain_ram.sv =====
// Eight-word chaining memory; entries not yet written read as the initial hash.
module sha256_chain_ram (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clr,
  input  logic        we,
  input  logic [2:0]  wa,
  input  logic [31:0] wd,
  input  logic [2:0]  ra,
  output logic [31:0] q
);

  logic [31:0] mem [8];
  logic [31:0] q_r;
  logic [7:0]  vld_r;
  logic        qv_r;
  logic [2:0]  qa_r;

  // Track written entries; clear returns every entry to the initial hash
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wa] <= 1'b1;
    end
  end

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    q_r  <= mem[ra];
    qv_r <= vld_r[ra];
    qa_r <= ra;
  end

  assign q = qv_r ? q_r : sha256_pkg::init_hash(qa_r);

endmodule
